/* src/bsfe_pkg.sv */
// bsfe_pkg: shared types and constants for the byte stuffed frame encoder
// no dependencies
package bsfe_pkg;

  localparam logic [7:0]  MARKER_BYTE  = 8'h5A;
  localparam logic [7:0]  ESCAPE_BYTE  = 8'h5B;
  localparam logic [7:0]  ESC_MARKER   = 8'h01;
  localparam logic [7:0]  ESC_ESCAPE   = 8'h02;
  localparam logic [15:0] LEN_OVERHEAD = 16'd5;

  // one classified input transfer, as handed from front to back
  typedef struct packed {
    logic       first;
    logic       last;
    logic [7:0] len_hi;
    logic [7:0] len_lo;
    logic [7:0] data;
    logic [7:0] csum;
  } job_t;

  // which part of the frame the back end is emitting
  typedef enum logic [2:0] {
    SEG_START,
    SEG_HI,
    SEG_LO,
    SEG_DATA,
    SEG_CSUM,
    SEG_END
  } seg_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* src/byte_stuffed_frame_encoder.sv */
// byte_stuffed_frame_encoder: top level, front + job queue + back end
// depends on bsfe_pkg, bsfe_front, bsfe_queue, bsfe_back
//
// Encodes message bytes into a byte stuffed frame: start marker 0x5A, 16-bit
// total length (message_length + 5, high byte first), the body, an 8-bit
// additive checksum over length and body, and end marker 0x5A. Marker and
// escape bytes between the markers are escaped (0x5A -> 0x5B 0x01, 0x5B ->
// 0x5B 0x02). The front takes one input transfer per cycle while the job
// queue has room, updates the running checksum and queues a job; the back
// end emits one output byte per cycle from the queue head while the queue
// holds a job and the output is not stalled. Rate is set by the single
// output byte per cycle: a body byte costs one output byte, two if escaped,
// a first byte adds 3 to 5 header bytes, a last byte adds 2 to 3 bytes of
// checksum and end marker. QUEUE_DEPTH jobs may be buffered, letting the
// input run ahead of a stalled output. run_end flags the last byte caused
// by an input transfer, frame_end flags the closing marker.
module byte_stuffed_frame_encoder
  import bsfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  message_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [15:0] message_length,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_end,
  output logic        frame_end
);

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head_job;
  q_status_t q_status;

  // classify and checksum
  bsfe_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .message_byte   (message_byte),
    .first_byte     (first_byte),
    .last_byte      (last_byte),
    .message_length (message_length),
    .q_status       (q_status),
    .in_stall       (in_stall),
    .push           (push),
    .push_job       (push_job)
  );

  // decouples input transfers from output byte rate
  bsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  // frame sequencing, escaping and output register
  bsfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .frame_end (frame_end)
  );

  // closing marker is always the marker value
  a_end_is_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> out_byte == MARKER_BYTE)
    else $error("frame_end on a non-marker byte");

  // closing marker always ends its input's run
  a_end_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_end)
    else $error("frame_end without run_end");

  // an accepted transfer leaves a job in the queue
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !q_status.empty)
    else $error("accepted transfer lost from queue");

  // no pop from an empty queue
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop on empty queue");

endmodule

/* src/bsfe_front.sv */
// bsfe_front: accepts input transfers, builds header bytes, keeps the checksum
// depends on bsfe_pkg
module bsfe_front
  import bsfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  message_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [15:0] message_length,
  input  q_status_t   q_status,
  output logic        in_stall,
  output logic        push,
  output job_t        push_job
);

  logic [7:0]  running_sum;
  logic [7:0]  running_sum_next;
  logic [15:0] total_len;
  logic [7:0]  base_sum;
  logic [7:0]  new_sum;

  assign in_stall  = q_status.full;
  assign push      = in_valid && !q_status.full;
  assign total_len = message_length + LEN_OVERHEAD;

  always_comb begin
    // a first byte restarts the sum from the length bytes
    base_sum = first_byte ? (total_len[15:8] + total_len[7:0]) : running_sum;
    new_sum  = base_sum + message_byte;
    running_sum_next = running_sum;
    if (push) begin
      running_sum_next = last_byte ? 8'h00 : new_sum;
    end
  end

  always_comb begin
    push_job.first  = first_byte;
    push_job.last   = last_byte;
    push_job.len_hi = total_len[15:8];
    push_job.len_lo = total_len[7:0];
    push_job.data   = message_byte;
    push_job.csum   = new_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'h00;
    end else begin
      running_sum <= running_sum_next;
    end
  end

endmodule

/* src/bsfe_queue.sv */
// bsfe_queue: short register queue of jobs between front and back
// depends on bsfe_pkg
module bsfe_queue
  import bsfe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t q_status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head_job       = slots[rd_ptr];
  assign q_status.full  = (count == FULL_CNT);
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/bsfe_back.sv */
// bsfe_back: walks one job through its frame parts, escapes, drives output register
// depends on bsfe_pkg
module bsfe_back
  import bsfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_t      head_job,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_byte,
  output logic      run_end,
  output logic      frame_end
);

  seg_t       seg;
  seg_t       seg_next;
  seg_t       cur_seg;
  logic       begun;
  logic       begun_next;
  logic       esc_pending;
  logic       esc_pending_next;
  logic       fire;
  logic [7:0] cur_val;
  logic       needs_esc;
  logic [7:0] emit_byte;
  logic       byte_done;
  logic       job_done;

  assign fire    = !q_status.empty && (!out_valid || !out_stall);
  assign cur_seg = begun ? seg : (head_job.first ? SEG_START : SEG_DATA);
  assign pop     = fire && job_done;

  // output decode for the current part
  always_comb begin
    cur_val   = MARKER_BYTE;
    needs_esc = 1'b0;
    unique case (cur_seg)
      SEG_START: cur_val = MARKER_BYTE;
      SEG_HI:    cur_val = head_job.len_hi;
      SEG_LO:    cur_val = head_job.len_lo;
      SEG_DATA:  cur_val = head_job.data;
      SEG_CSUM:  cur_val = head_job.csum;
      SEG_END:   cur_val = MARKER_BYTE;
      default:   cur_val = MARKER_BYTE;
    endcase
    unique case (cur_seg) inside
      SEG_HI, SEG_LO, SEG_DATA, SEG_CSUM: needs_esc = 1'b1;
      default:                            needs_esc = 1'b0;
    endcase
    if (esc_pending) begin
      emit_byte = (cur_val == MARKER_BYTE) ? ESC_MARKER : ESC_ESCAPE;
      byte_done = 1'b1;
    end else if (needs_esc && (cur_val == MARKER_BYTE || cur_val == ESCAPE_BYTE)) begin
      emit_byte = ESCAPE_BYTE;
      byte_done = 1'b0;
    end else begin
      emit_byte = cur_val;
      byte_done = 1'b1;
    end
    job_done = byte_done &&
               ((cur_seg == SEG_END) || (cur_seg == SEG_DATA && !head_job.last));
  end

  // next part
  always_comb begin
    seg_next         = seg;
    begun_next       = begun;
    esc_pending_next = esc_pending;
    if (fire) begin
      esc_pending_next = !byte_done;
      if (job_done) begin
        begun_next = 1'b0;
        seg_next   = SEG_START;
      end else if (byte_done) begin
        begun_next = 1'b1;
        unique case (cur_seg)
          SEG_START: seg_next = SEG_HI;
          SEG_HI:    seg_next = SEG_LO;
          SEG_LO:    seg_next = SEG_DATA;
          SEG_DATA:  seg_next = SEG_CSUM;
          SEG_CSUM:  seg_next = SEG_END;
          default:   seg_next = SEG_START;
        endcase
      end else begin
        begun_next = 1'b1;
        seg_next   = cur_seg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg         <= SEG_START;
      begun       <= 1'b0;
      esc_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      seg         <= seg_next;
      begun       <= begun_next;
      esc_pending <= esc_pending_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte  <= emit_byte;
      run_end   <= job_done;
      frame_end <= byte_done && (cur_seg == SEG_END);
    end
  end

endmodule

/* tb/tb_byte_stuffed_frame_encoder.sv */
// tb_byte_stuffed_frame_encoder: self-checking bench for the byte stuffed frame encoder
// drives message bytes, predicts the escaped framed stream and checks every output transfer
// depends on bsfe_pkg and byte_stuffed_frame_encoder
`timescale 1ns / 100ps

module tb_byte_stuffed_frame_encoder
  import bsfe_pkg::*;
();

  localparam int TOTAL_TRANSFERS = 430;
  localparam int LONG_HOLD       = 200;
  localparam int SETTLE_CYCLES   = 20;

  // one expected byte of the framed stream
  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic       frame_end;
  } coded_byte_t;

  // one stimulus row; typed_bytes holds hand-written output, first byte in the top bits
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] len;
    logic [3:0]  n_typed;
    logic [79:0] typed_bytes;
  } msg_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  message_byte = 8'h00;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic [15:0] message_length = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        run_end;
  logic        frame_end;

  // predictor state: running checksum over length and body bytes
  logic [7:0]  checksum_acc = 8'h00;
  coded_byte_t stream_due[$];
  msg_row_t    directed_rows[$];
  coded_byte_t head_byte;

  // pacing controls shared by the sender and receiver processes
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit long_hold_req = 1'b0;
  int hold_cycles = 0;

  // run statistics
  int error_count = 0;
  int transfers_sent = 0;
  int bytes_seen = 0;
  int frames_closed = 0;
  int input_stall_cycles = 0;

  always #4 clk = ~clk;

  byte_stuffed_frame_encoder uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .message_byte   (message_byte),
    .first_byte     (first_byte),
    .last_byte      (last_byte),
    .message_length (message_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .run_end        (run_end),
    .frame_end      (frame_end)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic void push_byte(input logic [7:0] value, input logic fend);
    coded_byte_t b;
    b.value = value;
    b.run_end = 1'b0;
    b.frame_end = fend;
    stream_due.insert(stream_due.size(), b);
  endfunction

  // marker and escape bytes turn into a two-byte escape sequence
  function automatic void push_escaped(input logic [7:0] value);
    if (value == MARKER_BYTE) begin
      push_byte(ESCAPE_BYTE, 1'b0);
      push_byte(ESC_MARKER, 1'b0);
    end else if (value == ESCAPE_BYTE) begin
      push_byte(ESCAPE_BYTE, 1'b0);
      push_byte(ESC_ESCAPE, 1'b0);
    end else begin
      push_byte(value, 1'b0);
    end
  endfunction

  // flag the newest pending byte as the last one of its input transfer
  function automatic void mark_run_end();
    coded_byte_t b;
    b = stream_due.pop_back();
    b.run_end = 1'b1;
    stream_due.insert(stream_due.size(), b);
  endfunction

  // expected stream for one accepted input transfer
  function automatic void predict_framing(input logic [7:0] data, input logic first,
                                          input logic last, input logic [15:0] len);
    logic [15:0] total;
    total = len + LEN_OVERHEAD;
    if (first) begin
      // a new header also drops whatever frame was still open
      push_byte(MARKER_BYTE, 1'b0);
      push_escaped(total[15:8]);
      push_escaped(total[7:0]);
      checksum_acc = total[15:8] + total[7:0];
    end
    push_escaped(data);
    checksum_acc = checksum_acc + data;
    if (last) begin
      push_escaped(checksum_acc);
      push_byte(MARKER_BYTE, 1'b1);
      checksum_acc = 8'h00;
    end
    mark_run_end();
  endfunction

  function automatic void add_row(input logic [7:0] data, input logic first, input logic last,
                                  input logic [15:0] len, input int n_typed,
                                  input logic [79:0] typed_bytes);
    msg_row_t r;
    r.data = data;
    r.first = first;
    r.last = last;
    r.len = len;
    r.n_typed = 4'(n_typed);
    r.typed_bytes = typed_bytes;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // random body byte, weighted toward the two bytes that need escaping
  function automatic logic [7:0] pick_body_byte();
    case ($urandom_range(0, 7))
      0: pick_body_byte = MARKER_BYTE;
      1: pick_body_byte = ESCAPE_BYTE;
      default: pick_body_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one transfer, after a random gap while send_idle is set; called and returns at a falling edge
  task automatic send_transfer(input msg_row_t r);
    int gap;
    int mark;
    int i;
    coded_byte_t scratch;
    gap = send_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    message_byte <= r.data;
    first_byte <= r.first;
    last_byte <= r.last;
    message_length <= r.len;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    // transfer accepted at this edge
    transfers_sent++;
    mark = stream_due.size();
    predict_framing(r.data, r.first, r.last, r.len);
    if (r.n_typed != 0) begin
      // hand-written rows replace the predicted bytes, state still follows the predictor
      while (stream_due.size() > mark) scratch = stream_due.pop_back();
      for (i = 0; i < r.n_typed; i++)
        push_byte(r.typed_bytes[79 - 8 * i -: 8], r.last && (i == r.n_typed - 1));
      mark_run_end();
    end
    @(negedge clk);
  endtask

  function automatic msg_row_t make_row(input logic [7:0] data, input logic first,
                                        input logic last, input logic [15:0] len);
    msg_row_t r;
    r.data = data;
    r.first = first;
    r.last = last;
    r.len = len;
    r.n_typed = 4'd0;
    r.typed_bytes = '0;
    return r;
  endfunction

  // sender holds off until every pending byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (stream_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver stalls for a long stretch while a back-to-back frame is offered,
  // so the job queue fills up and the block pushes back on its input
  task automatic apply_backpressure();
    int i;
    send_idle = 1'b0;
    long_hold_req = 1'b1;
    for (i = 0; i < 12; i++)
      send_transfer(make_row(pick_body_byte(), i == 0, i == 11, 16'd12));
    wait_drained();
  endtask

  // output monitor: sampled at the rising edge, checks each accepted transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      bytes_seen++;
      if (frame_end === 1'b1) frames_closed++;
      if (stream_due.size() == 0) begin
        report_mismatch("output transfer with nothing pending, out_byte", out_byte, 0);
      end else begin
        head_byte = stream_due.pop_front();
        if (out_byte !== head_byte.value)
          report_mismatch("out_byte", out_byte, head_byte.value);
        if (run_end !== head_byte.run_end)
          report_mismatch("run_end", run_end, head_byte.run_end);
        if (frame_end !== head_byte.frame_end)
          report_mismatch("frame_end", frame_end, head_byte.frame_end);
      end
      // fresh stall draw before the next output transfer
      hold_cycles = recv_idle ? $urandom_range(0, 10) : 0;
    end
  end

  // receiver stall driver, counts its own hold-off cycles
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cycles = LONG_HOLD;
    end
    out_stall <= (hold_cycles != 0);
    if (hold_cycles != 0) hold_cycles--;
  end

  initial begin
    int r_idx;
    int shape;
    int body;
    int i;
    logic [15:0] declared;
    logic f;
    logic l;
    bit pressure_done;

    pressure_done = 1'b0;

    // typed rows: fresh frames whose bytes read straight off the framing rules
    add_row(8'h00, 1, 1, 16'h0001, 6, 80'h5A_00_06_00_06_5A_00_00_00_00);
    add_row(8'hFF, 1, 1, 16'hFFFF, 6, 80'h5A_00_04_FF_03_5A_00_00_00_00);
    // both length bytes equal to the marker, body byte too
    add_row(8'h5A, 1, 1, 16'h5A55, 9, 80'h5A_5B_01_5B_01_5B_01_0E_5A_00);
    // length bytes marker then escape, body byte escape
    add_row(8'h5B, 1, 1, 16'h5A56, 9, 80'h5A_5B_01_5B_02_5B_02_10_5A_00);
    // total length wraps to zero
    add_row(8'h00, 1, 1, 16'hFFFB, 6, 80'h5A_00_00_00_00_5A_00_00_00_00);
    // ordinary three-byte frame
    add_row(8'h5A, 1, 0, 16'h0003, 0, '0);
    add_row(8'h5B, 0, 0, 16'h0000, 0, '0);
    add_row(8'h11, 0, 1, 16'hFFFF, 0, '0);
    // open frame cut off by a new first byte
    add_row(8'h01, 1, 0, 16'h000A, 0, '0);
    add_row(8'h7F, 0, 0, 16'h0000, 0, '0);
    add_row(8'h02, 1, 0, 16'h0002, 0, '0);
    add_row(8'h80, 0, 1, 16'h0000, 0, '0);
    // stray byte outside any frame, then a last with no first
    add_row(8'h5B, 0, 0, 16'h0000, 0, '0);
    add_row(8'hFF, 0, 1, 16'h0000, 0, '0);
    add_row(8'h5B, 0, 1, 16'hFFFF, 0, '0);
    // declared length disagrees with the body actually sent
    add_row(8'h33, 1, 0, 16'h0000, 0, '0);
    add_row(8'h44, 0, 0, 16'h0000, 0, '0);
    add_row(8'h55, 0, 1, 16'h0000, 0, '0);
    add_row(8'hC3, 1, 1, 16'h0064, 0, '0);
    add_row(8'hAA, 0, 0, 16'h5555, 0, '0);
    add_row(8'h00, 0, 1, 16'hAAAA, 0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (r_idx = 0; r_idx < directed_rows.size(); r_idx++)
      send_transfer(directed_rows[r_idx]);
    wait_drained();
    apply_backpressure();

    // random frames: mostly well formed with random content, some broken
    while (transfers_sent < TOTAL_TRANSFERS) begin
      send_idle = ($urandom_range(0, 4) != 0);
      recv_idle = ($urandom_range(0, 4) != 0);
      shape = $urandom_range(0, 19);
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      if (shape == 0) begin
        // noise: a lone transfer with random flags
        send_transfer(make_row(pick_body_byte(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))));
      end else begin
        declared = 16'(body);
        if (shape == 2) declared = 16'($urandom_range(0, 65535));
        if (shape == 4) declared = 16'($urandom_range(65530, 65535));
        for (i = 0; i < body; i++) begin
          // shape 1 never closes, shape 3 never opens
          f = (i == 0) && (shape != 3);
          l = (i == body - 1) && (shape != 1);
          send_transfer(make_row(pick_body_byte(), f, l,
                                 f ? declared : 16'($urandom_range(0, 65535))));
        end
      end
      if (!pressure_done && transfers_sent > 220) begin
        pressure_done = 1'b1;
        wait_drained();
        apply_backpressure();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d input transfers and %0d output bytes in %0d closed frames",
             transfers_sent, bytes_seen, frames_closed);
    $display("input was pushed back for %0d cycles, %0d mismatches logged",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5000000;
    $display("watchdog expired with %0d output bytes still pending", stream_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
